@@ sv/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared widths, reset values and controller/datapath interface types
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int PAGE_W   = 8;   // page number width
  localparam int CFG_W    = 4;   // capacity register width
  localparam int COUNT_W  = 4;   // reported resident count width

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture a new reference
    logic rd_scan;   // read list entry at idx
    logic idx_inc;   // advance scan index
    logic found;     // scan hit at idx
    logic miss;      // scan ended without a hit
    logic mv_rd;     // read list entry at idx-1
    logic mv_wr;     // write that entry to idx, step idx down
    logic wr_front;  // write page to slot 0 and publish result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic occ_zero;  // list empty
    logic match;     // read entry equals page
    logic last;      // idx is the last occupied slot
    logic idx_zero;  // idx at slot 0
  } sts_t;

endpackage

@@ sv/lrupr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrupr_ctrl
// sequencer for scan, eviction decision and list shift
// ----------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lrupr_pkg::sts_t   sts,
  output lrupr_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MISS,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_MV_RD,
    ST_MV_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.occ_zero ? ST_MISS : ST_SCAN_RD;
        end
      end
      ST_MISS: begin
        cmd.miss  = 1'b1;
        state_nxt = ST_MV_RD;
      end
      ST_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts.match) begin
          cmd.found = 1'b1;
          state_nxt = ST_MV_RD;
        end else if (sts.last) begin
          cmd.miss  = 1'b1;
          state_nxt = ST_MV_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_MV_RD: begin
        if (sts.idx_zero) begin
          cmd.wr_front = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.mv_rd = 1'b1;
          state_nxt = ST_MV_WR;
        end
      end
      ST_MV_WR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = ST_MV_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r)
    else $error("accepted reference did not raise busy");

  a_front_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_front |=> !busy_r)
    else $error("busy after front write");

endmodule

@@ sv/lrupr_dp.sv @@
// ----------------------------------------------------------------------------
// lrupr_dp
// recency list memory, occupancy, capacity register and result registers
// ----------------------------------------------------------------------------
module lrupr_dp #(
  parameter int CAPACITY = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lrupr_pkg::cmd_t                   cmd,
  output lrupr_pkg::sts_t                   sts,
  input  logic [lrupr_pkg::PAGE_W-1:0]      in_page,
  input  logic                              cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]       cfg_capacity_in_use,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic                              out_evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]      out_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]     out_resident_count
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // clamp capacity register to 1..CAPACITY
  function automatic logic [CNTW-1:0] eff_cap(input logic [lrupr_pkg::CFG_W-1:0] c);
    int v;
    v = int'(c);
    if (v < 1) v = 1;
    if (v > CAPACITY) v = CAPACITY;
    return CNTW'(v);
  endfunction

  logic [lrupr_pkg::PAGE_W-1:0] mem [CAPACITY];

  logic [lrupr_pkg::PAGE_W-1:0]  rdata_r;
  logic [lrupr_pkg::PAGE_W-1:0]  page_r;
  logic [IDXW-1:0]               idx_r;
  logic [CNTW-1:0]               occ_r;
  logic [lrupr_pkg::CFG_W-1:0]   cap_r;
  logic                          hit_r;
  logic                          ev_r;
  logic [lrupr_pkg::PAGE_W-1:0]  evpg_r;
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic                          out_ev_r;
  logic [lrupr_pkg::PAGE_W-1:0]  out_evpg_r;
  logic [lrupr_pkg::COUNT_W-1:0] out_cnt_r;

  logic [CNTW-1:0]               cap_w;
  logic [CNTW-1:0]               cfg_cap_w;
  logic                          full_w;
  logic [IDXW-1:0]               rd_addr;
  logic [IDXW-1:0]               wr_addr;
  logic [lrupr_pkg::PAGE_W-1:0]  wr_data;
  logic                          wr_en;

  assign cap_w     = eff_cap(cap_r);
  assign cfg_cap_w = eff_cap(cfg_capacity_in_use);
  assign full_w    = (occ_r >= cap_w);

  assign sts.occ_zero = (occ_r == '0);
  assign sts.match    = (rdata_r == page_r);
  assign sts.last     = ((CNTW'(idx_r) + CNTW'(1)) == occ_r);
  assign sts.idx_zero = (idx_r == '0);

  assign rd_addr = cmd.mv_rd ? IDXW'(idx_r - IDXW'(1)) : idx_r;
  assign wr_en   = cmd.mv_wr | cmd.wr_front;
  assign wr_addr = cmd.wr_front ? '0 : idx_r;
  assign wr_data = cmd.wr_front ? page_r : rdata_r;

  // list storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_scan || cmd.mv_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cap_r       <= lrupr_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.wr_front;
      if (cfg_we) begin
        cap_r <= cfg_capacity_in_use;
        if (occ_r > cfg_cap_w) begin
          occ_r <= cfg_cap_w;
        end
      end else if (cmd.miss && !full_w) begin
        occ_r <= occ_r + CNTW'(1);
      end
    end
  end

  // per-reference working registers and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page;
      idx_r  <= '0;
      hit_r  <= 1'b0;
      ev_r   <= 1'b0;
      evpg_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDXW'(1);
    end else if (cmd.found) begin
      hit_r <= 1'b1;
    end else if (cmd.miss) begin
      if (full_w) begin
        // last scanned entry is the least recent one
        ev_r   <= 1'b1;
        evpg_r <= rdata_r;
        idx_r  <= IDXW'(cap_w - CNTW'(1));
      end else begin
        idx_r <= IDXW'(occ_r);
      end
    end else if (cmd.mv_wr) begin
      idx_r <= idx_r - IDXW'(1);
    end
    if (cmd.wr_front) begin
      out_hit_r  <= hit_r;
      out_ev_r   <= ev_r;
      out_evpg_r <= evpg_r;
      out_cnt_r  <= lrupr_pkg::COUNT_W'(occ_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_evicted_valid  = out_ev_r;
  assign out_evicted_page   = out_evpg_r;
  assign out_resident_count = out_cnt_r;

  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cap_w)
    else $error("occupancy above capacity");

  a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> occ_r != '0)
    else $error("result with empty list");

  a_ev_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> !out_hit_r)
    else $error("eviction reported on a hit");

endmodule

@@ sv/lru_page_replacement_core.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// least-recently-used page tracker with eviction report
// ----------------------------------------------------------------------------
// One page reference is taken when start is high and busy is low; its result
// appears on the out_ ports for exactly one cycle with out_valid high, and the
// receiver cannot hold it off. The recency list lives in a single memory
// with one read and one write per cycle: the scan reads a slot and then
// compares it, and the move-to-front reads a slot and then writes it one
// slot further back. An empty list skips the scan. busy stays high until the
// strobe cycle, in which the next reference can already be accepted. The
// capacity register is written through cfg_valid/cfg_ready (ready while not
// busy); lowering it drops the least recent pages silently. A value of 0 acts
// as 1 and values above CAPACITY act as CAPACITY. No clearing pass is needed
// after reset: only occupied slots are ever read.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
  parameter int CAPACITY = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // reference channel
  input  logic                              start,
  output logic                              busy,
  input  logic [lrupr_pkg::PAGE_W-1:0]      in_page,
  // result channel, one-cycle strobe
  output logic                              out_valid,
  output logic                              out_hit,
  output logic                              out_evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]      out_evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]     out_resident_count,
  // capacity register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]       cfg_capacity_in_use
);

  lrupr_pkg::cmd_t cmd;
  lrupr_pkg::sts_t sts;
  logic            cfg_we;

  // config transfer only between references
  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  // sequencer: scan, hit/miss decision, shift, front write
  lrupr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // list memory, occupancy, capacity and result registers
  lrupr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_page             (in_page),
    .cfg_we              (cfg_we),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_resident_count  (out_resident_count)
  );

endmodule

@@ verif/tb_lru_page_replacement_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_core
// self-checking bench for the lru page tracker
// ----------------------------------------------------------------------------
// A behavioral copy of the recency list predicts hit, eviction and resident
// count for every accepted reference. Directed tests cover the field
// extremes, hits on the front and rear entries, eviction from a full list,
// capacity cut below occupancy, and the out-of-range capacity values.
// Random traffic then runs under several capacity settings with three sender
// idle profiles.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_core;

  localparam int SLOTS = 8;                 // CAPACITY of the instance
  localparam int SEGMENT_REFS = 210;        // references per random segment

  // one predicted result transfer
  typedef struct packed {
    logic                          hit;
    logic                          ev_valid;
    logic [lrupr_pkg::PAGE_W-1:0]  ev_page;
    logic [lrupr_pkg::COUNT_W-1:0] count;
  } page_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // every input held at a known value from time zero
  logic                         start = 1'b0;
  logic [lrupr_pkg::PAGE_W-1:0] in_page = '0;
  logic                         cfg_valid = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]  cfg_capacity_in_use = '0;

  logic                          busy;
  logic                          out_valid;
  logic                          out_hit;
  logic                          out_evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]  out_evicted_page;
  logic [lrupr_pkg::COUNT_W-1:0] out_resident_count;
  logic                          cfg_ready;

  // predictor state: slot 0 is the most recent page
  logic [lrupr_pkg::PAGE_W-1:0] lru_order [SLOTS];
  int unsigned                  resident_pages;
  logic [lrupr_pkg::CFG_W-1:0]  capacity_reg;

  page_result_t pending_results [$];
  int unsigned  error_count = 0;
  int unsigned  sender_idle_pct = 0;

  lru_page_replacement_core #(
    .CAPACITY(SLOTS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_page            (in_page),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_page   (out_evicted_page),
    .out_resident_count (out_resident_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_in_use(cfg_capacity_in_use)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero behaves as one slot, anything past the list size as the full list
  function automatic int unsigned slots_in_use();
    int unsigned c;
    c = capacity_reg;
    if (c < 1) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  // register write: pages past the new limit fall off silently
  function automatic void apply_capacity(input logic [lrupr_pkg::CFG_W-1:0] value);
    capacity_reg = value;
    if (resident_pages > slots_in_use()) resident_pages = slots_in_use();
  endfunction

  // looks the page up, updates the recency order and returns the result
  function automatic page_result_t lookup_page(input logic [lrupr_pkg::PAGE_W-1:0] pg);
    page_result_t r;
    int unsigned  lim;
    int unsigned  pos;
    bit           found;
    lim = slots_in_use();
    if (resident_pages > lim) resident_pages = lim;
    found = 1'b0;
    pos = 0;
    r = '0;
    // first match wins; pages are unique in the list anyway
    for (int unsigned i = 0; i < resident_pages; i++) begin
      if (!found && lru_order[i] == pg) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (!found) begin
      if (resident_pages >= lim) begin
        // full list: the rear slot goes, everything above it shifts down
        r.ev_valid = 1'b1;
        r.ev_page = lru_order[lim-1];
        pos = lim - 1;
      end else begin
        pos = resident_pages;
        resident_pages++;
      end
    end
    for (int unsigned i = pos; i > 0; i--) lru_order[i] = lru_order[i-1];
    lru_order[0] = pg;
    r.hit = found;
    r.count = lrupr_pkg::COUNT_W'(resident_pages);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: result transfer with nothing expected, hit %0b evicted %0b/%0h count %0d",
                 $time, out_hit, out_evicted_valid, out_evicted_page, out_resident_count);
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", want.hit, out_hit);
        compare_field("evicted_valid", want.ev_valid, out_evicted_valid);
        compare_field("evicted_page", want.ev_page, out_evicted_page);
        compare_field("resident_count", want.count, out_resident_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  // one reference transfer; start is left high so a following reference can
  // go back to back, callers that stop sending lower it at the next fall
  task automatic send_reference(input logic [lrupr_pkg::PAGE_W-1:0] pg);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_page <= pg;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(lookup_page(pg));
  endtask

  // stop sending and let every outstanding result drain
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // capacity write, only on an idle block
  task automatic write_capacity(input logic [lrupr_pkg::CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity_in_use <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_capacity(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset capacity, extreme pages, hits on the rear and the front entries
  task automatic test_first_references();
    send_reference(8'h00);
    send_reference(8'hFF);
    send_reference(8'h00);   // rear of two
    send_reference(8'hFF);   // rear again
    send_reference(8'hFF);   // front
  endtask

  // fill the list, evict from it, hit the least recent slot when full
  task automatic test_fill_and_evict();
    send_reference(8'hAA);
    send_reference(8'h55);
    send_reference(8'h01);
    send_reference(8'h80);
    send_reference(8'h7F);
    send_reference(8'hFE);   // list now full
    send_reference(8'h42);   // evicts 00
    send_reference(8'hFF);   // hit on the rear slot
    send_reference(8'h10);   // evicts aa
  endtask

  // lowering the capacity below occupancy drops the oldest pages unreported
  task automatic test_capacity_shrink();
    write_capacity(4'd3);
    send_reference(8'hFE);   // was dropped, so a miss that evicts
    send_reference(8'h10);
  endtask

  // zero acts as a single slot, fifteen as the whole list
  task automatic test_capacity_limits();
    write_capacity(4'd0);
    send_reference(8'hFE);
    send_reference(8'h33);
    write_capacity(4'hF);
    send_reference(8'hC3);
    send_reference(8'h3C);
  endtask

  function automatic logic [lrupr_pkg::CFG_W-1:0] planned_capacity(input int unsigned seg);
    case (seg)
      0: return 4'd8;
      1: return 4'd1;
      2: return 4'd15;
      3: return 4'd0;
      4: return 4'd5;
      5: return 4'd8;
      6: return 4'd2;
      7: return 4'd7;
      default: return 4'd12;
    endcase
  endfunction

  // random references, mostly from a narrow window so that hits and
  // evictions both stay frequent, now and then any page at all
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned first_seg);
    logic [lrupr_pkg::PAGE_W-1:0] window_base;
    logic [lrupr_pkg::PAGE_W-1:0] pg;
    sender_idle_pct = idle_pct;
    for (int unsigned s = 0; s < 3; s++) begin
      write_capacity(planned_capacity(first_seg + s));
      window_base = lrupr_pkg::PAGE_W'($urandom_range(0, 255));
      for (int unsigned n = 0; n < SEGMENT_REFS; n++) begin
        if ($urandom_range(0, 99) < 80)
          pg = window_base + lrupr_pkg::PAGE_W'($urandom_range(0, slots_in_use() + 3));
        else
          pg = lrupr_pkg::PAGE_W'($urandom_range(0, 255));
        send_reference(pg);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < SLOTS; i++) lru_order[i] = '0;
    resident_pages = 0;
    capacity_reg = lrupr_pkg::CFG_RESET;

    // synchronous reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_references();
    test_fill_and_evict();
    test_capacity_shrink();
    test_capacity_limits();

    test_random_traffic(13, 0);
    test_random_traffic(67, 3);
    test_random_traffic(0, 6);

    // let the last result land, then watch for stray strobes
    drain_results();
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_lru_page_replacement_core: clean");
    end else begin
      $display("tb_lru_page_replacement_core: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #6000000;
    $display("tb_lru_page_replacement_core: errors");
    $finish;
  end

endmodule

@@ lru_page_replacement_core.f @@
sv/lrupr_pkg.sv
sv/lrupr_ctrl.sv
sv/lrupr_dp.sv
sv/lru_page_replacement_core.sv
verif/tb_lru_page_replacement_core.sv
